FILE: design/afrb_pkg.sv
`timescale 1ns / 1ps
// afrb_pkg: shared types, field widths, register offsets and codes for the
// audio FIFO register block. No dependencies.

package afrb_pkg;

  // stream field widths
  localparam int unsigned TYPE_W      = 2;
  localparam int unsigned ADDR_W      = 12;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned IN_TDATA_W  = 80;  // 12 + 32 + 32 bits, padded to bytes
  localparam int unsigned OUT_TDATA_W = 40;  // 32 + 1 + 1 + 1 bits, padded to bytes

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLK_EN   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RST_HOLD = 1'd1;

  // fifo sizing
  localparam int unsigned FIFO_DEPTH_DEF = 32;
  localparam int unsigned THR_W          = 6;
  localparam int unsigned THR_LSB        = 16;

  // front-to-back queue
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;
  localparam int unsigned Q_CNT_W = 2;

  // request kinds
  localparam logic [TYPE_W-1:0] REQ_READ  = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_WRITE = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_DRAIN = 2'd2;
  localparam logic [TYPE_W-1:0] REQ_ADC   = 2'd3;

  // register offsets
  localparam logic [ADDR_W-1:0] ADDR_DAC       = 12'h000;
  localparam logic [ADDR_W-1:0] ADDR_STATUS    = 12'h004;
  localparam logic [ADDR_W-1:0] ADDR_CMD       = 12'h068;
  localparam logic [ADDR_W-1:0] ADDR_ADC_DATA  = 12'h06C;
  localparam logic [ADDR_W-1:0] ADDR_RX_CTL    = 12'h080;
  localparam logic [ADDR_W-1:0] ADDR_RX_STAT   = 12'h084;
  localparam logic [ADDR_W-1:0] ADDR_RX_DATA   = 12'h088;
  localparam logic [ADDR_W-1:0] ADDR_TX_CTL    = 12'h08C;
  localparam logic [ADDR_W-1:0] ADDR_TX_STAT   = 12'h090;
  localparam logic [ADDR_W-1:0] ADDR_TX_DATA   = 12'h094;
  localparam logic [ADDR_W-1:0] ADDR_RX_CTL2   = 12'h880;
  localparam logic [ADDR_W-1:0] ADDR_RX_STAT2  = 12'h884;
  localparam logic [ADDR_W-1:0] ADDR_RX_DATA2  = 12'h888;

  // plain settings registers
  localparam int unsigned NUM_PLAIN   = 14;
  localparam int unsigned PLAIN_IDX_W = 4;
  localparam int unsigned IDX_CMD     = 6;
  localparam int unsigned IDX_ITF     = 8;
  localparam logic [ADDR_W-1:0] PLAIN_OFFS [NUM_PLAIN] = '{
    12'h008, 12'h00C, 12'h010, 12'h014, 12'h060, 12'h064, 12'h068,
    12'h800, 12'h804, 12'h808, 12'h80C, 12'h810, 12'h81C, 12'h838
  };

  // bit positions and masks
  localparam logic [DATA_W-1:0] LOW24      = 32'h00FF_FFFF;
  localparam logic [DATA_W-1:0] TX_CH_MASK = 32'h0000_0300;
  localparam logic [DATA_W-1:0] RX_CH_MASK = 32'h0000_0700;
  localparam int unsigned SOFT_FLUSH_BIT = 29;
  localparam int unsigned RX_ITF_BIT     = 30;
  localparam int unsigned READY_BIT      = 24;
  localparam int unsigned DAC_EN0_BIT    = 0;
  localparam int unsigned DAC_EN1_BIT    = 1;
  localparam int unsigned DAC_EN2_BIT    = 27;
  localparam int unsigned CTL_FLUSH      = 0;
  localparam int unsigned CTL_OVR_IE     = 1;
  localparam int unsigned CTL_UDR_IE     = 2;
  localparam int unsigned CTL_AVL_IE     = 3;
  localparam int unsigned CTL_DMA_EN     = 4;
  localparam int unsigned FLAG_OVR       = 0;
  localparam int unsigned FLAG_UDR       = 1;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_RD_DAC,
    OP_RD_STATUS,
    OP_RD_ADC,
    OP_RD_RX_CTL,
    OP_RD_RX_STAT,
    OP_RD_POP,
    OP_RD_TX_CTL,
    OP_RD_TX_STAT,
    OP_RD_PLAIN,
    OP_WR_DAC,
    OP_WR_CMD,
    OP_WR_RX_CTL,
    OP_WR_TX_CTL,
    OP_WR_PUSH,
    OP_WR_PLAIN,
    OP_DRAIN,
    OP_ADC_PUSH
  } op_e;

  typedef struct packed {
    op_e                    op;
    logic [PLAIN_IDX_W-1:0] idx;
    logic [DATA_W-1:0]      data;
  } op_t;

endpackage

FILE: design/audio_fifo_register_block_core.sv
`timescale 1ns / 1ps
// Audio FIFO register block, top level.
// Requests enter on the s_axis channel: tuser carries the request kind
// (0 bus read, 1 bus write, 2 tx drain tick, 3 adc sample push) and tdata
// carries address, write data and adc sample. Every request yields exactly
// one result on m_axis: read data plus the irq and the two dma request lines
// as they stand after the request has taken effect.
// The front classifies a request and writes it into a two-entry queue; the
// back executes one operation at a time (execute, then result), the result
// step waiting on the registered read port of the RX sample store.
// A request passes the queue, the execute step and the output register; the
// back takes no new operation until the last result has been loaded.
// If m_axis stalls, the finished result stays in the output register and
// the queue keeps accepting until both entries are taken, then tready drops.
// Reset clears the register file, flags and FIFO levels; clock_enable comes up
// as 1 and reset_hold as 0. Writing reset_hold to 1 over the cfg port clears
// the same register file, flags and levels. Config writes belong in idle periods only.
// Depends on afrb_pkg, afrb_front, afrb_queue and afrb_back.

module audio_fifo_register_block_core #(
  parameter int unsigned FIFO_DEPTH = afrb_pkg::FIFO_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [afrb_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // address, write_data, adc_sample
  input  logic [afrb_pkg::TYPE_W-1:0]        s_axis_tuser,  // req_type
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [afrb_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // read_data, irq, rx_dma, tx_dma
  input  logic                               cfg_we_i,
  input  logic [afrb_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [afrb_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import afrb_pkg::*;

  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

  op_t                front_op, queue_op;
  logic               push, pop, q_empty, q_full;
  logic [Q_CNT_W-1:0] q_cnt;
  logic [CW-1:0]      rx_level, tx_level;

  afrb_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full_i      (q_full),
    .push_o        (push),
    .op_o          (front_op)
  );

  afrb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (front_op),
    .pop_i   (pop),
    .op_o    (queue_op),
    .empty_o (q_empty),
    .full_o  (q_full),
    .count_o (q_cnt)
  );

  afrb_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (queue_op),
    .op_valid_i    (!q_empty),
    .op_pop_o      (pop),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .rx_level_o    (rx_level),
    .tx_level_o    (tx_level)
  );

  // fifo levels never pass the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_level <= CW'(FIFO_DEPTH))
    else $error("rx level above fifo depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_level <= CW'(FIFO_DEPTH))
    else $error("tx level above fifo depth");

  // a full queue must hold off the front
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_cnt == Q_CNT_W'(Q_DEPTH)) |-> !s_axis_tready)
    else $error("front ready while queue full");

  // the back only pops an operation that is there
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (q_cnt != '0))
    else $error("back popped an empty queue");

endmodule

FILE: design/afrb_front.sv
`timescale 1ns / 1ps
// afrb_front: accepts stream items and classifies them into operations
// for the back end. Depends on afrb_pkg.

module afrb_front (
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [afrb_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // address, write_data, adc_sample
  input  logic [afrb_pkg::TYPE_W-1:0]       s_axis_tuser,  // req_type
  input  logic                              q_full_i,
  output logic                              push_o,
  output afrb_pkg::op_t                     op_o
);
  import afrb_pkg::*;

  logic [ADDR_W-1:0]      addr;
  logic [DATA_W-1:0]      wdata;
  logic [DATA_W-1:0]      sample;
  logic                   plain_hit;
  logic [PLAIN_IDX_W-1:0] plain_idx;

  assign addr   = s_axis_tdata[ADDR_W-1:0];
  assign wdata  = s_axis_tdata[ADDR_W +: DATA_W];
  assign sample = s_axis_tdata[ADDR_W+DATA_W +: DATA_W];

  assign s_axis_tready = !q_full_i;
  assign push_o        = s_axis_tvalid && !q_full_i;

  // settings register lookup, offsets are unique
  always_comb begin
    plain_hit = 1'b0;
    plain_idx = '0;
    for (int i = 0; i < NUM_PLAIN; i++) begin
      if (PLAIN_OFFS[i] == addr) begin
        plain_hit = 1'b1;
        plain_idx = PLAIN_IDX_W'(i);
      end
    end
  end

  always_comb begin
    op_o.op   = OP_NOP;
    op_o.idx  = plain_idx;
    op_o.data = wdata;
    case (s_axis_tuser)
      REQ_READ: begin
        case (addr)
          ADDR_DAC:                    op_o.op = OP_RD_DAC;
          ADDR_STATUS:                 op_o.op = OP_RD_STATUS;
          ADDR_ADC_DATA:               op_o.op = OP_RD_ADC;
          ADDR_RX_CTL, ADDR_RX_CTL2:   op_o.op = OP_RD_RX_CTL;
          ADDR_RX_STAT, ADDR_RX_STAT2: op_o.op = OP_RD_RX_STAT;
          ADDR_RX_DATA, ADDR_RX_DATA2: op_o.op = OP_RD_POP;
          ADDR_TX_CTL:                 op_o.op = OP_RD_TX_CTL;
          ADDR_TX_STAT:                op_o.op = OP_RD_TX_STAT;
          default:                     op_o.op = plain_hit ? OP_RD_PLAIN : OP_NOP;
        endcase
      end
      REQ_WRITE: begin
        case (addr)
          ADDR_DAC:                  op_o.op = OP_WR_DAC;
          ADDR_CMD:                  op_o.op = OP_WR_CMD;
          ADDR_RX_CTL, ADDR_RX_CTL2: op_o.op = OP_WR_RX_CTL;
          ADDR_TX_CTL:               op_o.op = OP_WR_TX_CTL;
          ADDR_TX_DATA:              op_o.op = OP_WR_PUSH;
          // status, data and unknown offsets are read only or absent
          ADDR_STATUS, ADDR_ADC_DATA, ADDR_RX_STAT, ADDR_RX_STAT2,
          ADDR_RX_DATA, ADDR_RX_DATA2, ADDR_TX_STAT: op_o.op = OP_NOP;
          default:                   op_o.op = plain_hit ? OP_WR_PLAIN : OP_NOP;
        endcase
      end
      REQ_DRAIN: op_o.op = OP_DRAIN;
      REQ_ADC: begin
        op_o.op   = OP_ADC_PUSH;
        op_o.data = sample;
      end
      default: op_o.op = OP_NOP;
    endcase
  end

endmodule

FILE: design/afrb_queue.sv
`timescale 1ns / 1ps
// afrb_queue: two-entry queue of classified operations between the front
// and the back end. Depends on afrb_pkg.

module afrb_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  afrb_pkg::op_t               op_i,
  input  logic                        pop_i,
  output afrb_pkg::op_t               op_o,
  output logic                        empty_o,
  output logic                        full_o,
  output logic [afrb_pkg::Q_CNT_W-1:0] count_o
);
  import afrb_pkg::*;

  op_t                entry_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign count_o = cnt_q;
  assign op_o    = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

FILE: design/afrb_back.sv
`timescale 1ns / 1ps
// afrb_back: executes operations against the register file, the RX FIFO
// store and the TX fill count, and registers one result per operation.
// Depends on afrb_pkg.

module afrb_back #(
  parameter int unsigned FIFO_DEPTH = afrb_pkg::FIFO_DEPTH_DEF,
  localparam int unsigned PW = $clog2(FIFO_DEPTH),
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  afrb_pkg::op_t                      op_i,
  input  logic                               op_valid_i,
  output logic                               op_pop_o,
  input  logic                               cfg_we_i,
  input  logic [afrb_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [afrb_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [afrb_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // read_data, irq, rx_dma, tx_dma
  output logic [CW-1:0]                      rx_level_o,
  output logic [CW-1:0]                      tx_level_o
);
  import afrb_pkg::*;

  localparam logic PH_EXEC   = 1'b0;
  localparam logic PH_RESULT = 1'b1;
  localparam logic [1:0] SEL_REG = 2'd0;
  localparam logic [1:0] SEL_POP = 2'd1;
  localparam logic [1:0] SEL_ADC = 2'd2;

  // control and register state
  logic              phase_q, phase_d;
  logic [1:0]        sel_q, sel_d;
  logic              clk_en_q, clk_en_d;
  logic              hold_q, hold_d;
  logic [DATA_W-1:0] dac_q, dac_d;
  logic [DATA_W-1:0] plain_q [NUM_PLAIN];
  logic [DATA_W-1:0] plain_d [NUM_PLAIN];
  logic [DATA_W-1:0] adc_q, adc_d;
  logic [DATA_W-1:0] txctl_q, txctl_d;
  logic [DATA_W-1:0] rxctl_q, rxctl_d;
  logic [1:0]        txflg_q, txflg_d;
  logic [1:0]        rxflg_q, rxflg_d;
  logic [CW-1:0]     tx_cnt_q, tx_cnt_d;
  logic [CW-1:0]     rx_cnt_q, rx_cnt_d;
  logic [PW-1:0]     rx_head_q, rx_head_d;
  logic [PW-1:0]     rx_tail_q, rx_tail_d;
  logic              out_valid_q, out_valid_d;

  // payload
  logic [DATA_W-1:0]      rd_q, rd_d;
  logic                   had_q, had_d;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;
  logic [DATA_W-1:0]      rx_mem [FIFO_DEPTH];
  logic [DATA_W-1:0]      mem_rdata_q;
  logic                   mem_we, mem_re;

  // derived views
  logic              clk_act, tx_on, rx_on, pending;
  logic [THR_W-1:0]  rx_lvl, tx_lvl, rx_thr, tx_thr;
  logic [CW-1:0]     tx_free;
  logic              load;
  logic [DATA_W-1:0] adc_new, rd_final;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [DATA_W-1:0] status_word(input logic [1:0] flg,
                                                    input logic [THR_W-1:0] lvl,
                                                    input logic [THR_W-1:0] thr);
    logic [DATA_W-1:0] s;
    s = '0;
    s[FLAG_UDR+1:FLAG_OVR+1]  = flg;
    s[CTL_DMA_EN]             = (lvl > thr);
    s[THR_LSB +: THR_W]       = lvl;
    return s;
  endfunction

  function automatic logic side_irq(input logic [DATA_W-1:0] ctrl, input logic [1:0] flg,
                                    input logic [THR_W-1:0] lvl);
    return (ctrl[CTL_AVL_IE] && (lvl > ctrl[THR_LSB +: THR_W])) ||
           (ctrl[CTL_UDR_IE] && flg[FLAG_UDR]) ||
           (ctrl[CTL_OVR_IE] && flg[FLAG_OVR]);
  endfunction

  assign clk_act = clk_en_q && !hold_q;
  assign tx_on   = clk_act && dac_q[DAC_EN0_BIT] && dac_q[DAC_EN1_BIT] &&
                   dac_q[DAC_EN2_BIT] && |(txctl_q & TX_CH_MASK);
  assign rx_on   = clk_act && plain_q[IDX_ITF][RX_ITF_BIT] && |(rxctl_q & RX_CH_MASK);
  assign tx_free = CW'(FIFO_DEPTH) - tx_cnt_q;
  assign rx_lvl  = THR_W'(rx_cnt_q);
  assign tx_lvl  = THR_W'(tx_free);
  assign rx_thr  = rxctl_q[THR_LSB +: THR_W];
  assign tx_thr  = txctl_q[THR_LSB +: THR_W];
  assign pending = side_irq(txctl_q, txflg_q, tx_lvl) || side_irq(rxctl_q, rxflg_q, rx_lvl);

  assign adc_new = had_q ? ((mem_rdata_q & LOW24) | (DATA_W'(1) << READY_BIT))
                         : (adc_q & ~(DATA_W'(1) << READY_BIT));

  always_comb begin
    case (sel_q)
      SEL_POP: rd_final = mem_rdata_q;
      SEL_ADC: rd_final = adc_new;
      default: rd_final = rd_q;
    endcase
  end

  assign load          = (phase_q == PH_RESULT) && (!out_valid_q || m_axis_tready);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign rx_level_o    = rx_cnt_q;
  assign tx_level_o    = tx_cnt_q;

  always_comb begin
    phase_d     = phase_q;
    sel_d       = sel_q;
    clk_en_d    = clk_en_q;
    hold_d      = hold_q;
    dac_d       = dac_q;
    plain_d     = plain_q;
    adc_d       = adc_q;
    txctl_d     = txctl_q;
    rxctl_d     = rxctl_q;
    txflg_d     = txflg_q;
    rxflg_d     = rxflg_q;
    tx_cnt_d    = tx_cnt_q;
    rx_cnt_d    = rx_cnt_q;
    rx_head_d   = rx_head_q;
    rx_tail_d   = rx_tail_q;
    rd_d        = rd_q;
    had_d       = had_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    op_pop_o    = 1'b0;

    case (phase_q)
      PH_EXEC: begin
        if (op_valid_i) begin
          op_pop_o = 1'b1;
          phase_d  = PH_RESULT;
          sel_d    = SEL_REG;
          rd_d     = '0;
          case (op_i.op)
            OP_RD_DAC:     rd_d = dac_q;
            OP_RD_STATUS:  rd_d = DATA_W'(pending);
            OP_RD_ADC: begin
              // head word comes from the store on the next cycle
              sel_d  = SEL_ADC;
              had_d  = (rx_cnt_q != '0);
              mem_re = 1'b1;
            end
            OP_RD_RX_CTL:  rd_d = rxctl_q;
            OP_RD_RX_STAT: rd_d = status_word(rxflg_q, rx_lvl, rx_thr);
            OP_RD_POP: begin
              if (rx_cnt_q == '0) begin
                rxflg_d[FLAG_UDR] = 1'b1;
              end else begin
                sel_d     = SEL_POP;
                mem_re    = 1'b1;
                rx_head_d = ptr_inc(rx_head_q);
                rx_cnt_d  = rx_cnt_q - 1'b1;
              end
            end
            OP_RD_TX_CTL:  rd_d = txctl_q;
            OP_RD_TX_STAT: rd_d = status_word(txflg_q, tx_lvl, tx_thr);
            OP_RD_PLAIN:   rd_d = plain_q[op_i.idx];
            OP_WR_DAC: begin
              if (!hold_q) begin
                dac_d = op_i.data;
              end
            end
            OP_WR_CMD: begin
              if (!hold_q) begin
                plain_d[IDX_CMD] = op_i.data;
                if (op_i.data[SOFT_FLUSH_BIT]) begin
                  rx_head_d = '0;
                  rx_tail_d = '0;
                  rx_cnt_d  = '0;
                  rxflg_d   = '0;
                  adc_d     = '0;
                end
              end
            end
            OP_WR_RX_CTL: begin
              if (!hold_q) begin
                if (op_i.data[CTL_FLUSH]) begin
                  rx_head_d = '0;
                  rx_tail_d = '0;
                  rx_cnt_d  = '0;
                  rxflg_d   = '0;
                end
                rxctl_d = op_i.data & ~(DATA_W'(1) << CTL_FLUSH);
              end
            end
            OP_WR_TX_CTL: begin
              if (!hold_q) begin
                if (op_i.data[CTL_FLUSH]) begin
                  tx_cnt_d = '0;
                  txflg_d  = '0;
                end
                txctl_d = op_i.data & ~(DATA_W'(1) << CTL_FLUSH);
              end
            end
            OP_WR_PUSH: begin
              // tx words leave through the fill count only
              if (!hold_q) begin
                if (tx_cnt_q == CW'(FIFO_DEPTH)) begin
                  txflg_d[FLAG_OVR] = 1'b1;
                end else begin
                  tx_cnt_d = tx_cnt_q + 1'b1;
                end
              end
            end
            OP_WR_PLAIN: begin
              if (!hold_q) begin
                plain_d[op_i.idx] = op_i.data;
              end
            end
            OP_DRAIN: begin
              if (tx_on) begin
                tx_cnt_d = '0;
              end
            end
            OP_ADC_PUSH: begin
              if (!hold_q) begin
                if (rx_cnt_q == CW'(FIFO_DEPTH)) begin
                  rxflg_d[FLAG_OVR] = 1'b1;
                end else begin
                  mem_we    = 1'b1;
                  rx_tail_d = ptr_inc(rx_tail_q);
                  rx_cnt_d  = rx_cnt_q + 1'b1;
                end
              end
            end
            default: rd_d = '0;
          endcase
        end
      end
      PH_RESULT: begin
        if (load) begin
          phase_d     = PH_EXEC;
          out_valid_d = 1'b1;
          out_data_d  = {5'b0,
                         tx_on && txctl_q[CTL_DMA_EN] && (tx_lvl > tx_thr),
                         rx_on && rxctl_q[CTL_DMA_EN] && (rx_lvl > rx_thr),
                         clk_act && pending,
                         rd_final};
          if (sel_q == SEL_ADC) begin
            adc_d = adc_new;
          end
        end
      end
      default: phase_d = PH_EXEC;
    endcase

    // the user must make configuration writes only while the block is idle; the block does not enforce this
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CLK_EN: clk_en_d = cfg_data_i[0];
        CFG_RST_HOLD: begin
          hold_d = cfg_data_i[0];
          if (cfg_data_i[0]) begin
            dac_d     = '0;
            adc_d     = '0;
            txctl_d   = '0;
            rxctl_d   = '0;
            txflg_d   = '0;
            rxflg_d   = '0;
            tx_cnt_d  = '0;
            rx_cnt_d  = '0;
            rx_head_d = '0;
            rx_tail_d = '0;
            for (int i = 0; i < NUM_PLAIN; i++) begin
              plain_d[i] = '0;
            end
          end
        end
        default: hold_d = hold_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_EXEC;
      sel_q       <= SEL_REG;
      clk_en_q    <= 1'b1;
      hold_q      <= 1'b0;
      dac_q       <= '0;
      adc_q       <= '0;
      txctl_q     <= '0;
      rxctl_q     <= '0;
      txflg_q     <= '0;
      rxflg_q     <= '0;
      tx_cnt_q    <= '0;
      rx_cnt_q    <= '0;
      rx_head_q   <= '0;
      rx_tail_q   <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_PLAIN; i++) begin
        plain_q[i] <= '0;
      end
    end else begin
      phase_q     <= phase_d;
      sel_q       <= sel_d;
      clk_en_q    <= clk_en_d;
      hold_q      <= hold_d;
      dac_q       <= dac_d;
      adc_q       <= adc_d;
      txctl_q     <= txctl_d;
      rxctl_q     <= rxctl_d;
      txflg_q     <= txflg_d;
      rxflg_q     <= rxflg_d;
      tx_cnt_q    <= tx_cnt_d;
      rx_cnt_q    <= rx_cnt_d;
      rx_head_q   <= rx_head_d;
      rx_tail_q   <= rx_tail_d;
      out_valid_q <= out_valid_d;
      plain_q     <= plain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q       <= rd_d;
    had_q      <= had_d;
    out_data_q <= out_data_d;
  end

  // rx store: one write port at the tail, one registered read port at the head
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      rx_mem[rx_tail_q] <= op_i.data;
    end
    if (mem_re) begin
      mem_rdata_q <= rx_mem[rx_head_q];
    end
  end

endmodule
